// ===== hw/rtl/hhpf_pkg.sv =====
// Shared types, constants and method-name tables for the HTTP host packet filter.
`default_nettype none
package hhpf_pkg;

    localparam int MAX_PATTERN_BYTES = 32;
    localparam int PAT_IDX_W         = $clog2(MAX_PATTERN_BYTES);
    localparam int PLEN_W            = 6;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 64;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
    localparam int METHOD_COUNT      = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_PAT0     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PAT1     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PAT2     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PAT3     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PLEN     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PORT     = 3'd5;

    localparam logic [15:0] DEFAULT_PORT = 16'd80;
    localparam logic [7:0]  PROTO_TCP    = 8'h06;
    localparam logic [7:0]  CHAR_CR      = 8'h0D;
    localparam logic [7:0]  CHAR_LF      = 8'h0A;

    localparam logic [2:0] CAUSE_HOST      = 3'd0;
    localparam logic [2:0] CAUSE_NOT_TCP   = 3'd1;
    localparam logic [2:0] CAUSE_PORT      = 3'd2;
    localparam logic [2:0] CAUSE_NO_PAYLD  = 3'd3;
    localparam logic [2:0] CAUSE_NO_METHOD = 3'd4;
    localparam logic [2:0] CAUSE_NO_LINE2  = 3'd5;
    localparam logic [2:0] CAUSE_NO_HOST   = 3'd6;
    localparam logic [2:0] CAUSE_TRUNC     = 3'd7;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        delim;
        logic        zero;
        logic [15:0] pos;
    } beat_t;

    typedef struct packed {
        logic [8*MAX_PATTERN_BYTES-1:0] pattern;
        logic [PLEN_W-1:0]              plen;
        logic [15:0]                    port;
    } cfg_t;

    function automatic logic [2:0] method_len(input int unsigned i);
        case (i)
            0: method_len = 3'd3;
            1: method_len = 3'd4;
            2: method_len = 3'd4;
            3: method_len = 3'd3;
            4: method_len = 3'd6;
            5: method_len = 3'd7;
            6: method_len = 3'd7;
            7: method_len = 3'd5;
            8: method_len = 3'd5;
            default: method_len = 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] method_char(input int unsigned i, input logic [2:0] col);
        logic [8*8-1:0] name;
        case (i)
            0: name = "GET";
            1: name = "HEAD";
            2: name = "POST";
            3: name = "PUT";
            4: name = "DELETE";
            5: name = "CONNECT";
            6: name = "OPTIONS";
            7: name = "TRACE";
            8: name = "PATCH";
            default: name = '0;
        endcase
        // string literal is right-aligned: first char sits at byte (len-1)
        method_char = name[8*(int'(method_len(i)) - 1 - int'(col)) +: 8];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hhpf_front.sv =====
// Front end: accepts byte beats, tags position and character class, pushes into the queue.
`default_nettype none
module hhpf_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    packet_byte,
    input  wire logic          end_of_packet,
    input  wire logic          q_full,
    output logic               q_push,
    output hhpf_pkg::beat_t    q_beat
);

    logic [15:0] pos_reg, pos_next;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        q_beat.data  = packet_byte;
        q_beat.last  = end_of_packet;
        q_beat.delim = (packet_byte == hhpf_pkg::CHAR_CR) || (packet_byte == hhpf_pkg::CHAR_LF);
        q_beat.zero  = (packet_byte == 8'h00);
        q_beat.pos   = pos_reg;
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (q_push)
        begin
            if (end_of_packet)
                pos_next = '0;
            else if (pos_reg != 16'hFFFF)
                pos_next = pos_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/hhpf_queue.sv =====
// Small register queue decoupling the front end from the parser.
`default_nettype none
module hhpf_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire hhpf_pkg::beat_t push_beat,
    output logic               full,
    input  wire logic          pop,
    output logic               nonempty,
    output hhpf_pkg::beat_t    head_beat
);

    hhpf_pkg::beat_t                 slot_reg [hhpf_pkg::QUEUE_DEPTH];
    logic [hhpf_pkg::QPTR_W-1:0]     rd_reg, rd_next, wr_reg, wr_next;
    logic [hhpf_pkg::QPTR_W:0]       cnt_reg, cnt_next;

    assign full      = (cnt_reg == (hhpf_pkg::QPTR_W+1)'(hhpf_pkg::QUEUE_DEPTH));
    assign nonempty  = (cnt_reg != '0);
    assign head_beat = slot_reg[rd_reg];

    always_comb
    begin
        rd_next  = rd_reg;
        wr_next  = wr_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = wr_reg + 1'b1;
        if (pop)
            rd_next = rd_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_beat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/hhpf_back.sv =====
// Back end: header and payload parser, host matcher and verdict output register.
`default_nettype none
module hhpf_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire hhpf_pkg::cfg_t  cfg,
    input  wire logic          q_nonempty,
    input  wire hhpf_pkg::beat_t beat,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic               drop,
    output logic [2:0]         verdict_cause
);

    localparam logic [2:0] PH_HEADER   = 3'd0;
    localparam logic [2:0] PH_DONE     = 3'd1;
    localparam logic [2:0] PH_LEAD     = 3'd2;
    localparam logic [2:0] PH_LINE1    = 3'd3;
    localparam logic [2:0] PH_LINE1_OK = 3'd4;
    localparam logic [2:0] PH_MID      = 3'd5;
    localparam logic [2:0] PH_LINE2    = 3'd6;

    localparam int NP = hhpf_pkg::MAX_PATTERN_BYTES;
    localparam int CW = hhpf_pkg::PAT_IDX_W + 1;

    logic [2:0]  phase_reg, phase_next;
    logic [5:0]  ihl_reg, ihl_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] sport_reg, sport_next;
    logic [7:0]  dhigh_reg, dhigh_next;
    logic [15:0] poff_reg, poff_next;
    logic [8:0]  cand_reg, cand_next;
    logic [7:0]  col_reg, col_next;
    logic [7:0]  win_reg [NP];
    logic [7:0]  win_next [NP];
    logic [CW-1:0] count_reg, count_next;
    logic [2:0]  pend_reg, pend_next;
    logic        out_valid_reg, out_valid_next;
    logic        drop_reg, drop_next;
    logic [2:0]  cause_reg, cause_next;

    logic        out_free;
    logic [CW-1:0] plen_sat;
    logic [7:0]  aligned [NP];
    logic [NP-1:0] amask;

    logic [7:0]  l1_col;
    logic [8:0]  l1_cand, l1_cand_out;
    logic        l1_ok;
    logic [CW-1:0] l2_count;
    logic        l2_hit;

    function automatic logic [2:0] end_cause(input logic [2:0] ph, input logic [15:0] poff,
                                             input logic [2:0] pend);
        case (ph)
            PH_HEADER:   end_cause = (poff != '0) ? hhpf_pkg::CAUSE_NO_PAYLD
                                                  : hhpf_pkg::CAUSE_TRUNC;
            PH_LEAD,
            PH_LINE1:    end_cause = hhpf_pkg::CAUSE_NO_METHOD;
            PH_LINE1_OK,
            PH_MID:      end_cause = hhpf_pkg::CAUSE_NO_LINE2;
            PH_LINE2:    end_cause = hhpf_pkg::CAUSE_NO_HOST;
            default:     end_cause = pend;
        endcase
    endfunction

    assign out_free      = !out_valid_reg || out_ready;
    assign q_pop         = q_nonempty && (!beat.last || out_free);
    assign out_valid     = out_valid_reg;
    assign drop          = drop_reg;
    assign verdict_cause = cause_reg;

    // pattern right-aligned onto the newest bytes of the line window
    assign plen_sat = (cfg.plen > hhpf_pkg::PLEN_W'(NP)) ? CW'(NP) : CW'(cfg.plen);

    always_comb
    begin
        logic [CW:0] s;
        for (int j = 0; j < NP; j++)
        begin
            s = (CW+1)'(j) + (CW+1)'(plen_sat);
            amask[j]   = (s >= (CW+1)'(NP));
            aligned[j] = cfg.pattern[8*int'(s[hhpf_pkg::PAT_IDX_W-1:0]) +: 8];
        end
    end

    // first-line method matcher
    assign l1_col  = (phase_reg == PH_LEAD || phase_reg == PH_HEADER) ? 8'd0 : col_reg;
    assign l1_cand = (phase_reg == PH_LEAD || phase_reg == PH_HEADER) ? 9'h1FF : cand_reg;

    always_comb
    begin
        logic [7:0] ch;
        logic       lt;
        l1_cand_out = l1_cand;
        l1_ok       = 1'b0;
        for (int i = 0; i < hhpf_pkg::METHOD_COUNT; i++)
        begin
            ch = hhpf_pkg::method_char(i, l1_col[2:0]);
            lt = (l1_col < {5'd0, hhpf_pkg::method_len(i)});
            if (l1_cand[i] && lt && (ch != beat.data))
                l1_cand_out[i] = 1'b0;
            if (l1_cand[i] && lt && (ch == beat.data) &&
                (l1_col + 8'd1 == {5'd0, hhpf_pkg::method_len(i)}))
                l1_ok = 1'b1;
        end
    end

    // second-line host window compare, after this beat's shift
    always_comb
    begin
        logic [CW-1:0] c;
        logic [7:0]    nb;
        logic          all_eq;
        c = (phase_reg == PH_LINE2) ? count_reg : '0;
        l2_count = (c < CW'(NP)) ? c + 1'b1 : c;
        all_eq = 1'b1;
        for (int j = 0; j < NP; j++)
        begin
            nb = (j == NP-1) ? beat.data : win_reg[(j+1) % NP];
            if (amask[j] && (nb != aligned[j]))
                all_eq = 1'b0;
        end
        l2_hit = all_eq && (l2_count >= plen_sat);
    end

    always_comb
    begin
        logic [15:0] rel;
        logic [5:0]  doff;
        logic        do_payload;
        logic [2:0]  c;

        phase_next = phase_reg;
        ihl_next   = ihl_reg;
        total_next = total_reg;
        sport_next = sport_reg;
        dhigh_next = dhigh_reg;
        poff_next  = poff_reg;
        cand_next  = cand_reg;
        col_next   = col_reg;
        count_next = count_reg;
        pend_next  = pend_reg;
        for (int j = 0; j < NP; j++)
            win_next[j] = win_reg[j];
        out_valid_next = out_valid_reg && !out_ready;
        drop_next      = drop_reg;
        cause_next     = cause_reg;
        rel        = beat.pos - {10'd0, ihl_reg};
        doff       = {beat.data[7:4], 2'b00};
        do_payload = 1'b0;
        c          = '0;

        if (q_pop)
        begin
            if (phase_reg != PH_DONE && beat.pos != 16'hFFFF)
            begin
                if (phase_reg == PH_HEADER)
                begin
                    if (beat.pos == 16'd0)
                        ihl_next = {beat.data[3:0], 2'b00};
                    else if (beat.pos == 16'd2)
                        total_next = {beat.data, 8'h00};
                    else if (beat.pos == 16'd3)
                        total_next = {total_reg[15:8], beat.data};
                    else if (beat.pos == 16'd9)
                    begin
                        if (beat.data != hhpf_pkg::PROTO_TCP)
                        begin
                            pend_next  = hhpf_pkg::CAUSE_NOT_TCP;
                            phase_next = PH_DONE;
                        end
                        else if (ihl_reg < 6'd20)
                        begin
                            pend_next  = hhpf_pkg::CAUSE_TRUNC;
                            phase_next = PH_DONE;
                        end
                    end
                    else if (beat.pos >= 16'd20 && beat.pos >= {10'd0, ihl_reg})
                    begin
                        if (rel == 16'd0)
                            sport_next = {beat.data, 8'h00};
                        else if (rel == 16'd1)
                            sport_next = {sport_reg[15:8], beat.data};
                        else if (rel == 16'd2)
                            dhigh_next = beat.data;
                        else if (rel == 16'd3)
                        begin
                            if ({dhigh_reg, beat.data} != cfg.port && sport_reg != cfg.port)
                            begin
                                pend_next  = hhpf_pkg::CAUSE_PORT;
                                phase_next = PH_DONE;
                            end
                        end
                        else if (rel == 16'd12)
                        begin
                            if (doff < 6'd20)
                            begin
                                pend_next  = hhpf_pkg::CAUSE_TRUNC;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                poff_next = {9'd0, {1'b0, ihl_reg} + {1'b0, doff}};
                                if (total_reg <= poff_next)
                                begin
                                    pend_next  = hhpf_pkg::CAUSE_NO_PAYLD;
                                    phase_next = PH_DONE;
                                end
                            end
                        end
                        else if (poff_reg != '0 && beat.pos >= poff_reg)
                        begin
                            phase_next = PH_LEAD;
                            do_payload = 1'b1;
                        end
                    end
                end
                else if (beat.pos < total_reg)
                    do_payload = 1'b1;
            end

            if (do_payload)
            begin
                if (beat.zero)
                begin
                    pend_next  = end_cause(phase_next, poff_next, pend_reg);
                    phase_next = PH_DONE;
                end
                else
                begin
                    case (phase_next)
                        PH_LEAD,
                        PH_LINE1:
                        begin
                            if (beat.delim)
                            begin
                                if (phase_next == PH_LINE1)
                                begin
                                    pend_next  = hhpf_pkg::CAUSE_NO_METHOD;
                                    phase_next = PH_DONE;
                                end
                            end
                            else
                            begin
                                cand_next  = l1_cand_out;
                                col_next   = (l1_col == 8'hFF) ? l1_col : l1_col + 8'd1;
                                phase_next = l1_ok ? PH_LINE1_OK : PH_LINE1;
                            end
                        end
                        PH_LINE1_OK:
                        begin
                            if (beat.delim)
                                phase_next = PH_MID;
                        end
                        PH_MID,
                        PH_LINE2:
                        begin
                            if (beat.delim)
                            begin
                                if (phase_next == PH_LINE2)
                                begin
                                    pend_next  = hhpf_pkg::CAUSE_NO_HOST;
                                    phase_next = PH_DONE;
                                end
                            end
                            else
                            begin
                                for (int j = 0; j < NP-1; j++)
                                    win_next[j] = win_reg[j+1];
                                win_next[NP-1] = beat.data;
                                count_next = l2_count;
                                if (l2_hit)
                                begin
                                    pend_next  = hhpf_pkg::CAUSE_HOST;
                                    phase_next = PH_DONE;
                                end
                                else
                                    phase_next = PH_LINE2;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            if (beat.last)
            begin
                c = end_cause(phase_next, poff_next, pend_next);
                out_valid_next = 1'b1;
                drop_next      = (c == hhpf_pkg::CAUSE_HOST);
                cause_next     = c;
                phase_next = PH_HEADER;
                ihl_next   = '0;
                total_next = '0;
                sport_next = '0;
                dhigh_next = '0;
                poff_next  = '0;
                cand_next  = 9'h1FF;
                col_next   = '0;
                count_next = '0;
                pend_next  = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NP; j++)
            win_reg[j] <= win_next[j];
        drop_reg  <= drop_next;
        cause_reg <= cause_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            ihl_reg       <= '0;
            total_reg     <= '0;
            sport_reg     <= '0;
            dhigh_reg     <= '0;
            poff_reg      <= '0;
            cand_reg      <= 9'h1FF;
            col_reg       <= '0;
            count_reg     <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            ihl_reg       <= ihl_next;
            total_reg     <= total_next;
            sport_reg     <= sport_next;
            dhigh_reg     <= dhigh_next;
            poff_reg      <= poff_next;
            cand_reg      <= cand_next;
            col_reg       <= col_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && beat.last |=> out_valid_reg)
        else $error("last beat popped without a verdict");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && beat.last && out_valid_reg && !out_ready))
        else $error("verdict overwritten while pending");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(NP))
        else $error("line window count out of range");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && beat.last |=> phase_reg == PH_HEADER && poff_reg == '0)
        else $error("parser not cleared after verdict");

endmodule
`default_nettype wire

// ===== hw/rtl/http_host_packet_filter_top.sv =====
// Top level of the HTTP host packet filter: configuration registers and block wiring.
// Packets enter one byte per beat starting at the IPv4 header; one verdict beat (drop and
// cause) leaves after the beat marked end_of_packet. The block sustains one byte per cycle:
// the front end tags each byte, a four-entry queue buffers it, and the parser consumes one
// byte per cycle, stalling only when a verdict is ready while the previous one is still held
// in the output register. Each byte is registered in the queue, and each verdict in the output register.
// Configuration writes are taken every cycle and must only be made while no packet is open.
`default_nettype none
module http_host_packet_filter_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [7:0]                         packet_byte,
    input  wire logic                               end_of_packet,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    drop,
    output logic [2:0]                              verdict_cause,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [hhpf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [hhpf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    hhpf_pkg::cfg_t  cfg_reg, cfg_next;
    hhpf_pkg::beat_t push_beat, head_beat;
    logic            q_full, q_push, q_pop, q_nonempty;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hhpf_pkg::REG_PAT0: cfg_next.pattern[63:0]    = cfg_data;
                hhpf_pkg::REG_PAT1: cfg_next.pattern[127:64]  = cfg_data;
                hhpf_pkg::REG_PAT2: cfg_next.pattern[191:128] = cfg_data;
                hhpf_pkg::REG_PAT3: cfg_next.pattern[255:192] = cfg_data;
                hhpf_pkg::REG_PLEN: cfg_next.plen = cfg_data[hhpf_pkg::PLEN_W-1:0];
                hhpf_pkg::REG_PORT: cfg_next.port = cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern <= '0;
            cfg_reg.plen    <= '0;
            cfg_reg.port    <= hhpf_pkg::DEFAULT_PORT;
        end
        else
            cfg_reg <= cfg_next;
    end

    hhpf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .packet_byte   (packet_byte),
        .end_of_packet (end_of_packet),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_beat        (push_beat)
    );

    hhpf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_beat (push_beat),
        .full      (q_full),
        .pop       (q_pop),
        .nonempty  (q_nonempty),
        .head_beat (head_beat)
    );

    hhpf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_nonempty    (q_nonempty),
        .beat          (head_beat),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .drop          (drop),
        .verdict_cause (verdict_cause)
    );

endmodule
`default_nettype wire
